@@ hw/rtl/vn3_pkg.sv @@
package vn3_pkg;

  // Restoring divide steps: quotient bits 60 down to 0.
  localparam int DIV_STEPS  = 61;
  // Digit-by-digit square root steps: root bits 30 down to 0.
  localparam int SQRT_STEPS = 31;
  localparam int LANES      = 3;

  typedef struct packed {
    logic               func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } vn3_in_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic               zero_length;
  } vn3_out_t;

  // Side band that rides along the arithmetic pipe.
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } vn3_meta_t;

endpackage

@@ hw/rtl/vector_normalize_3d_core.sv @@
// Channel | Direction | Handshake          | Payload
// src     | in        | src_valid/src_stall | vn3_in_t  (func, a_*, b_*)
// res     | out       | res_valid/res_stall | vn3_out_t (unit_*, zero_length)
//
// One vector per cycle while the skid register is empty; the path from src transfer
// to res_valid runs through 3 front stages, 61 divide steps, 31 square root steps
// and the output register; the divider and root extractor resolve one bit per stage.
// rst (synchronous) clears only the valid bits; data registers are not reset.
// A stalled result parks in a skid register; the pipe freezes only while
// the skid is full, so src_stall is a register output.
module vector_normalize_3d_core import vn3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  vn3_in_t  src_data,
  output logic     res_valid,
  input  logic     res_stall,
  output vn3_out_t res_data
);

  logic en;
  logic skid_v;
  vn3_out_t skid;

  assign en        = !skid_v;
  assign src_stall = skid_v;

  // ---- stage A: difference, magnitude and sign ----
  logic        va;
  logic [31:0] mag [0:LANES-1];
  logic [2:0]  neg_a;
  logic signed [31:0] ca [0:LANES-1];
  logic signed [31:0] cb [0:LANES-1];

  assign ca[0] = src_data.a_x;
  assign ca[1] = src_data.a_y;
  assign ca[2] = src_data.a_z;
  assign cb[0] = src_data.b_x;
  assign cb[1] = src_data.b_y;
  assign cb[2] = src_data.b_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= src_valid;
    end
  end

  genvar l;
  generate
    for (l = 0; l < LANES; l++) begin : g_front
      logic signed [32:0] c;
      logic        [32:0] m;
      // a - b at 33 bits never wraps
      assign c = 33'(ca[l]) - (src_data.func ? 33'(cb[l]) : 33'sd0);
      assign m = c[32] ? 33'(-c) : 33'(c);
      always_ff @(posedge clk) begin
        if (en) begin
          mag[l]   <= m[31:0];
          neg_a[l] <= c[32];
        end
      end
    end
  endgenerate

  // ---- stage B: squares ----
  logic        vb;
  logic [63:0] sq [0:LANES-1];
  logic [2:0]  neg_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  generate
    for (l = 0; l < LANES; l++) begin : g_sq
      always_ff @(posedge clk) begin
        if (en) begin
          sq[l] <= mag[l] * mag[l];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b <= neg_a;
    end
  end

  // ---- stage C: sum of squares ----
  logic        vc;
  logic [63:0] sq_c [0:LANES-1];
  logic [65:0] sum_c;
  vn3_meta_t   meta_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c         <= sq;
      sum_c        <= 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
      meta_c.neg   <= neg_b;
      meta_c.zero  <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
    end
  end

  // ---- divide and root ----
  logic        vp;
  vn3_meta_t   meta_p;
  logic [30:0] root [0:LANES-1];

  vn3_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vc),
    .in_meta  (meta_c),
    .in_sq    (sq_c),
    .in_sum   (sum_c),
    .out_valid(vp),
    .out_meta (meta_p),
    .out_root (root)
  );

  // sign and zero handling
  logic signed [31:0] comp [0:LANES-1];
  vn3_out_t           res_new;

  generate
    for (l = 0; l < LANES; l++) begin : g_sign
      always_comb begin
        if (meta_p.zero) begin
          comp[l] = '0;
        end else if (meta_p.neg[l]) begin
          comp[l] = -$signed({1'b0, root[l]});
        end else begin
          comp[l] = $signed({1'b0, root[l]});
        end
      end
    end
  endgenerate

  assign res_new.unit_x      = comp[0];
  assign res_new.unit_y      = comp[1];
  assign res_new.unit_z      = comp[2];
  assign res_new.zero_length = meta_p.zero;

  // ---- output register with skid ----
  logic load_out;
  assign load_out = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (load_out) begin
      if (skid_v) begin
        res_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        res_valid <= vp;
      end
    end else if (en && vp) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_data <= skid_v ? skid : res_new;
    end else if (en && vp) begin
      skid <= res_new;
    end
  end

  // ---- checks ----
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.zero_length |->
      res_data.unit_x == 0 && res_data.unit_y == 0 && res_data.unit_z == 0)
    else $error("zero length result with nonzero components");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> res_valid)
    else $error("skid holds data while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(res_valid && res_stall))
    else $error("skid filled without a stalled result");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.unit_x <= 32'sd1073741824
      && res_data.unit_x >= -32'sd1073741824)
    else $error("unit component out of range");

endmodule

@@ hw/rtl/vn3_pipe.sv @@
module vn3_pipe import vn3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  vn3_meta_t        in_meta,
  input  logic [63:0]      in_sq [0:LANES-1],
  input  logic [65:0]      in_sum,
  output logic             out_valid,
  output vn3_meta_t        out_meta,
  output logic [30:0]      out_root [0:LANES-1]
);

  // divider state per step
  logic [66:0] drem [0:DIV_STEPS][0:LANES-1];
  logic [60:0] dquo [0:DIV_STEPS][0:LANES-1];
  logic [65:0] dsum [0:DIV_STEPS];
  vn3_meta_t   dmeta [0:DIV_STEPS];
  logic        dval [0:DIV_STEPS];

  // square root state per step
  logic [61:0] sx   [0:SQRT_STEPS][0:LANES-1];
  logic [61:0] sr   [0:SQRT_STEPS][0:LANES-1];
  vn3_meta_t   smeta [0:SQRT_STEPS];
  logic        sval [0:SQRT_STEPS];

  assign dval[0]  = in_valid;
  assign dmeta[0] = in_meta;
  assign dsum[0]  = in_sum;

  genvar k, l;
  generate
    for (l = 0; l < LANES; l++) begin : g_din
      assign drem[0][l] = {3'b000, in_sq[l]};
      assign dquo[0][l] = '0;
    end

    // quotient of sq * 2^60 / sum, one bit per step
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clk) begin
        if (rst) begin
          dval[k+1] <= 1'b0;
        end else if (en) begin
          dval[k+1] <= dval[k];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dmeta[k+1] <= dmeta[k];
          dsum[k+1]  <= dsum[k];
        end
      end
      for (l = 0; l < LANES; l++) begin : g_lane
        logic [66:0] trial;
        logic        ge;
        if (k == 0) begin : g_first
          assign trial = drem[k][l];
        end else begin : g_rest
          assign trial = {drem[k][l][65:0], 1'b0};
        end
        assign ge = trial >= {1'b0, dsum[k]};
        always_ff @(posedge clk) begin
          if (en) begin
            drem[k+1][l] <= ge ? trial - {1'b0, dsum[k]} : trial;
            dquo[k+1][l] <= {dquo[k][l][59:0], ge};
          end
        end
      end
    end

    assign sval[0]  = dval[DIV_STEPS];
    assign smeta[0] = dmeta[DIV_STEPS];
    for (l = 0; l < LANES; l++) begin : g_sin
      assign sx[0][l] = {1'b0, dquo[DIV_STEPS][l]};
      assign sr[0][l] = '0;
    end

    // integer square root of the quotient
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [61:0] ONE = 62'(1) << (60 - 2 * k);
      always_ff @(posedge clk) begin
        if (rst) begin
          sval[k+1] <= 1'b0;
        end else if (en) begin
          sval[k+1] <= sval[k];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          smeta[k+1] <= smeta[k];
        end
      end
      for (l = 0; l < LANES; l++) begin : g_lane
        logic [61:0] trial;
        logic        ge;
        assign trial = sr[k][l] + ONE;
        assign ge    = sx[k][l] >= trial;
        always_ff @(posedge clk) begin
          if (en) begin
            sx[k+1][l] <= ge ? sx[k][l] - trial : sx[k][l];
            sr[k+1][l] <= ge ? (sr[k][l] >> 1) + ONE : sr[k][l] >> 1;
          end
        end
      end
    end

    for (l = 0; l < LANES; l++) begin : g_out
      assign out_root[l] = sr[SQRT_STEPS][l][30:0];
    end
  endgenerate

  assign out_valid = sval[SQRT_STEPS];
  assign out_meta  = smeta[SQRT_STEPS];

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import vn3_pkg::*;

  logic     clk;
  logic     rst;
  logic     src_valid;
  logic     src_stall;
  vn3_in_t  src_data;
  logic     res_valid;
  logic     res_stall;
  vn3_out_t res_data;

  int unsigned errors = 0;

  vector_normalize_3d_core dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  task automatic report(input string what);
    errors++;
    $display("ERROR %s", what);
  endtask

  // Exact unit vector: largest q with q^2 * S <= m^2 * 2^60, sign of c.
  function automatic vn3_out_t unit_vector(input vn3_in_t v);
    logic signed [32:0] c [3];
    logic [32:0] m [3];
    logic [127:0] s, rhs, t2, prod;
    logic [31:0] q;
    logic [31:0] t;
    vn3_out_t r;
    s = '0;
    c[0] = 33'(v.a_x); c[1] = 33'(v.a_y); c[2] = 33'(v.a_z);
    if (v.func) begin
      c[0] = 33'(signed'(v.a_x)) - 33'(signed'(v.b_x));
      c[1] = 33'(signed'(v.a_y)) - 33'(signed'(v.b_y));
      c[2] = 33'(signed'(v.a_z)) - 33'(signed'(v.b_z));
    end
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i][32] ? 33'(-c[i]) : 33'(c[i]);
      s = s + 128'(m[i]) * 128'(m[i]);
    end
    r = '0;
    if (s == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      rhs = (128'(m[i]) * 128'(m[i])) << 60;
      q = 0;
      for (int b = 30; b >= 0; b--) begin
        t = q | (32'd1 << b);
        t2 = 128'(t) * 128'(t);
        prod = t2 * s;
        if (prod <= rhs) q = t;
      end
      if (c[i][32]) q = -q;
      if (i == 0) r.unit_x = q;
      else if (i == 1) r.unit_y = q;
      else r.unit_z = q;
    end
    return r;
  endfunction

  class unit_scoreboard;
    vn3_out_t pending[$];
    function void note_input(vn3_in_t v);
      pending.push_back(unit_vector(v));
    endfunction
    task check_result(vn3_out_t got);
      vn3_out_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.unit_x !== e.unit_x)
        report($sformatf("unit_x got %h want %h", got.unit_x, e.unit_x));
      if (got.unit_y !== e.unit_y)
        report($sformatf("unit_y got %h want %h", got.unit_y, e.unit_y));
      if (got.unit_z !== e.unit_z)
        report($sformatf("unit_z got %h want %h", got.unit_z, e.unit_z));
      if (got.zero_length !== e.zero_length)
        report($sformatf("zero_length got %b want %b", got.zero_length, e.zero_length));
    endtask
  endclass

  unit_scoreboard sb = new();
  bit quiet = 0;   // no idling in the last part of the run

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, check every transfer.
  initial begin
    int gap;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) sb.check_result(res_data);
      if (gap > 0) begin
        gap--;
        res_stall <= (gap > 0);
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        gap = $urandom_range(1, 14);
        res_stall <= 1'b1;
      end else res_stall <= 1'b0;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vn3_in_t rand_vec();
    vn3_in_t v;
    v.func = 1'($urandom_range(0, 1));
    v.a_x = rand_comp(); v.a_y = rand_comp(); v.a_z = rand_comp();
    v.b_x = rand_comp(); v.b_y = rand_comp(); v.b_z = rand_comp();
    if ($urandom_range(0, 15) == 0) begin
      v.b_x = v.a_x; v.b_y = v.a_y; v.b_z = v.a_z;  // a equal to b
    end
    if ($urandom_range(0, 15) == 0) begin   // axis aligned
      v.func = 0; v.a_y = 0; v.a_z = 0;
    end
    return v;
  endfunction

  // One transfer on the source side; idle burst ahead of it at random.
  task automatic send(input vn3_in_t v);
    if (!quiet && $urandom_range(0, 19) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= v;
    do @(posedge clk); while (src_stall);
    sb.note_input(v);
  endtask

  function automatic vn3_in_t mk(input logic f, input logic [31:0] ax, ay, az,
                                 input logic [31:0] bx, by, bz);
    vn3_in_t v;
    v.func = f; v.a_x = ax; v.a_y = ay; v.a_z = az;
    v.b_x = bx; v.b_y = by; v.b_z = bz;
    return v;
  endfunction

  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MAXN = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  initial begin
    int wait_n;
    rst = 1'b1;
    src_valid = 1'b0;
    src_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: zero, a equal b, axes, extremes, unused b, widest difference
    send(mk(0, 0, 0, 0, MAXP, MAXN, 32'h1234_5678));
    send(mk(1, MAXP, 5, MAXN, MAXP, 5, MAXN));
    send(mk(0, ONE, 0, 0, 0, 0, 0));
    send(mk(0, 0, -ONE, 0, 0, 0, 0));
    send(mk(0, 0, 0, MAXN, 0, 0, 0));
    send(mk(0, MAXP, 0, 0, 0, 0, 0));
    send(mk(0, MAXP, MAXP, MAXP, 0, 0, 0));
    send(mk(0, MAXN, MAXN, MAXN, 0, 0, 0));
    send(mk(0, MAXP, MAXN, 1, MAXN, MAXP, 0));
    send(mk(1, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN));
    send(mk(1, MAXN, MAXP, 0, MAXP, MAXN, 0));
    send(mk(1, 0, 0, 1, 0, 0, 0));
    send(mk(0, 1, 1, 1, 0, 0, 0));
    send(mk(0, -1, 1, -1, 0, 0, 0));
    send(mk(0, 3 * ONE, 4 * ONE, 0, 0, 0, 0));
    send(mk(1, 32'hffff_ffff, 0, 0, 32'h0000_0000, 0, 0));
    send(mk(0, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 0, 0, 0));
    send(mk(1, 32'h5555_5555, 32'haaaa_aaaa, 0, 32'haaaa_aaaa, 32'h5555_5555, 1));
    for (int i = 0; i < 1150; i++) begin
      if (i == 500) begin
        // hold off until the pipe has drained
        src_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if (i == 1000) quiet = 1;
      send(rand_vec());
    end
    src_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) $display("vector_normalize_3d_core: match");
    else $display("vector_normalize_3d_core: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("vector_normalize_3d_core: mismatch");
    $finish;
  end
endmodule

@@ vector_normalize_3d_core.f @@
hw/rtl/vn3_pkg.sv
hw/rtl/vn3_pipe.sv
hw/rtl/vector_normalize_3d_core.sv
test/tb_top.sv
